>>> rtl/salc_pkg.sv
// Shared types and codes for the set-associative LRU cache tag store.
package salc_pkg;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_WAYS       = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] address;
  } in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        last;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
  } out_t;

  typedef struct packed {
    logic accept;
    logic look;
    logic commit;
    logic second;
  } cmd_t;

  typedef struct packed {
    logic in_none;
    logic is_modify;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/salc_ctrl.sv
// Controller state machine that sequences each request through lookup and write-back.
module salc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  salc_pkg::sts_t sts,
  output salc_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOK   = 2'd1;
  localparam logic [1:0] S_CMP    = 2'd2;
  localparam logic [1:0] S_SECOND = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!sts.in_none) state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = sts.is_modify ? S_SECOND : S_IDLE;
        end
      end
      S_SECOND: begin
        if (sts.out_free) begin
          cmd.second = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/salc_dp.sv
// Datapath with configuration, set row memory, tag compare, LRU victim choice and totals.
module salc_dp #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [5:0]     cfg_data,
  input  salc_pkg::in_t  in_data,
  output salc_pkg::out_t out_data,
  output logic           out_valid,
  input  logic           out_ready,
  input  salc_pkg::cmd_t cmd,
  output salc_pkg::sts_t sts
);

  localparam int SW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NSETS = 1 << MAX_SET_BITS;
  localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int P     = 1 << WW;

  typedef struct packed {
    logic [MAX_WAYS-1:0]       valid;
    logic [MAX_WAYS-1:0][63:0] tag;
    logic [MAX_WAYS-1:0][31:0] stamp;
  } row_t;

  logic [2:0]  set_bits_r;
  logic [3:0]  ways_r;
  logic [5:0]  block_bits_r;
  logic [1:0]  kind_r;
  logic [63:0] addr_r;
  logic [31:0] stamp_r;
  logic [31:0] acc_stamp_r;
  logic [31:0] hits_r;
  logic [31:0] misses_r;
  logic [31:0] evicts_r;
  logic [63:0] tag_r;
  logic [SW-1:0] set_r;
  row_t        rd_r;
  logic        row_ok_q_r;
  logic [NSETS-1:0] row_ok_r;
  row_t        mem [NSETS];
  salc_pkg::out_t out_r;
  logic        out_valid_r;

  logic [2:0]    s_eff;
  logic [4:0]    e_eff;
  logic [63:0]   off;
  logic [SW-1:0] set_c;
  logic [6:0]    tag_sh;
  logic [63:0]   tag_c;
  logic          out_free;

  always_comb begin
    s_eff = (32'(set_bits_r) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_r;
    if (ways_r == 4'd0) e_eff = 5'd1;
    else if (32'(ways_r) > MAX_WAYS) e_eff = 5'(MAX_WAYS);
    else e_eff = {1'b0, ways_r};
    off    = addr_r >> block_bits_r;
    set_c  = off[SW-1:0] & ~({SW{1'b1}} << s_eff);
    tag_sh = 7'(s_eff) + 7'(block_bits_r);
    tag_c  = (tag_sh >= 7'd64) ? 64'd0 : (addr_r >> tag_sh[5:0]);
  end

  // Lookup evaluation on the registered row.
  logic [MAX_WAYS-1:0] vld, used, hitv;
  logic                hit, has_empty;
  logic [WW-1:0]       hit_way, empty_way, victim, way_sel;
  logic [31:0]         nd_stamp [2*P];
  logic [WW-1:0]       nd_idx   [2*P];
  logic                nd_ok    [2*P];
  row_t                wr_row;

  always_comb begin
    vld       = row_ok_q_r ? rd_r.valid : '0;
    hit       = 1'b0;
    has_empty = 1'b0;
    hit_way   = '0;
    empty_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      used[i] = (i < 32'(e_eff));
      hitv[i] = vld[i] && used[i] && (rd_r.tag[i] == tag_r);
    end
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hitv[i]) begin
        hit     = 1'b1;
        hit_way = WW'(i);
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (used[i] && !vld[i]) begin
        has_empty = 1'b1;
        empty_way = WW'(i);
      end
    end
    for (int i = 0; i < P; i++) begin
      nd_idx[P+i]   = WW'(i);
      nd_ok[P+i]    = (i < MAX_WAYS) ? used[i] : 1'b0;
      nd_stamp[P+i] = (i < MAX_WAYS) ? rd_r.stamp[i] : 32'd0;
    end
    nd_idx[0] = '0; nd_ok[0] = 1'b0; nd_stamp[0] = '0;
    for (int n = P - 1; n >= 1; n--) begin
      if (nd_ok[2*n] && (!nd_ok[2*n+1] || nd_stamp[2*n] <= nd_stamp[2*n+1])) begin
        nd_idx[n] = nd_idx[2*n]; nd_ok[n] = nd_ok[2*n]; nd_stamp[n] = nd_stamp[2*n];
      end else begin
        nd_idx[n] = nd_idx[2*n+1]; nd_ok[n] = nd_ok[2*n+1];
        nd_stamp[n] = nd_stamp[2*n+1];
      end
    end
    victim  = nd_idx[1];
    way_sel = hit ? hit_way : (has_empty ? empty_way : victim);
    wr_row        = rd_r;
    wr_row.valid  = vld;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WW'(i) == way_sel) begin
        wr_row.valid[i] = 1'b1;
        wr_row.tag[i]   = tag_r;
        wr_row.stamp[i] = stamp_r;
      end
    end
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  assign out_free      = !out_valid_r || out_ready;
  assign sts.out_free  = out_free;
  assign sts.is_modify = (kind_r == salc_pkg::KIND_MODIFY);
  assign sts.in_none   = (in_data.kind == salc_pkg::KIND_NONE);
  assign out_data      = out_r;
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      rd_r <= mem[set_c];
    end
    if (cmd.commit) begin
      mem[set_r] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 3'd0;
      ways_r       <= 4'd1;
      block_bits_r <= 6'd0;
      acc_stamp_r  <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
      evicts_r     <= '0;
      row_ok_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          salc_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_data[2:0];
          salc_pkg::CFG_WAYS:       ways_r       <= cfg_data[3:0];
          salc_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit || cmd.second) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.accept) acc_stamp_r <= sat_inc(acc_stamp_r);
      if (cmd.commit) begin
        row_ok_r[set_r] <= 1'b1;
        if (hit) begin
          hits_r <= sat_inc(hits_r);
        end else begin
          misses_r <= sat_inc(misses_r);
          if (!has_empty) evicts_r <= sat_inc(evicts_r);
        end
      end
      if (cmd.second) begin
        hits_r <= sat_inc(hits_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= in_data.kind;
      addr_r  <= in_data.address;
      stamp_r <= acc_stamp_r;
    end
    if (cmd.look) begin
      tag_r      <= tag_c;
      set_r      <= set_c;
      row_ok_q_r <= row_ok_r[set_c];
    end
    if (cmd.commit) begin
      out_r.last            <= (kind_r != salc_pkg::KIND_MODIFY);
      out_r.total_hits      <= hit ? sat_inc(hits_r) : hits_r;
      out_r.total_misses    <= hit ? misses_r : sat_inc(misses_r);
      out_r.total_evictions <= (!hit && !has_empty) ? sat_inc(evicts_r) : evicts_r;
      if (hit) out_r.outcome <= salc_pkg::OUT_HIT;
      else if (has_empty) out_r.outcome <= salc_pkg::OUT_FILL;
      else out_r.outcome <= salc_pkg::OUT_EVICT;
    end
    if (cmd.second) begin
      out_r.outcome         <= salc_pkg::OUT_HIT;
      out_r.last            <= 1'b1;
      out_r.total_hits      <= sat_inc(hits_r);
      out_r.total_misses    <= misses_r;
      out_r.total_evictions <= evicts_r;
    end
  end

endmodule

>>> rtl/set_assoc_lru_cache_sim.sv
// Top level of the set-associative LRU cache tag store.
// Each request is accepted in S_IDLE, its set row is read from a single-port row memory
// in S_LOOK, and compare, LRU choice and row write-back happen in S_CMP, where the result
// is registered; a modify then passes through S_SECOND for its second result (the second
// lookup always hits and reuses the written row). A request of the unused kind stays in
// S_IDLE and gives no result. A new request is taken while the last result still waits on
// out_ready, but its compare step stalls until that result has been taken.
// Each set has a row-valid flip-flop cleared by reset, so no clearing pass follows reset.
module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [5:0]     cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  salc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output salc_pkg::out_t out_data
);

  salc_pkg::cmd_t cmd;
  salc_pkg::sts_t sts;

  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  salc_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/salc_chk.sv
// Port-level checker for the cache tag store, bound to the top level.
module salc_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input salc_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == salc_pkg::OUT_HIT |-> out_data.total_hits != 32'd0)
    else $error("hit reported with zero hit total");

  a_evict_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == salc_pkg::OUT_EVICT
      |-> out_data.total_evictions != 32'd0 && out_data.total_misses != 32'd0)
    else $error("eviction reported with zero totals");

endmodule

bind set_assoc_lru_cache_sim salc_chk u_salc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/tb_top.sv
// Self-checking testbench for the set-associative LRU cache tag store.
class cache_scoreboard;
  salc_pkg::out_t pending[$];
  bit valid_q[512];
  logic [63:0] tag_q[512];
  logic [31:0] stamp_q[512];
  logic [31:0] acc_stamp, hits, misses, evicts;
  logic [2:0] set_bits;
  logic [3:0] ways;
  logic [5:0] block_bits;
  int errors;
  int results_seen;

  function new();
    set_bits = 0;
    ways = 1;
    block_bits = 0;
    acc_stamp = 0;
    hits = 0;
    misses = 0;
    evicts = 0;
    errors = 0;
    results_seen = 0;
    foreach (valid_q[i]) begin
      valid_q[i] = 0;
      tag_q[i] = 0;
      stamp_q[i] = 0;
    end
  endfunction

  function void set_reg(logic [1:0] idx, logic [5:0] val);
    if (idx == salc_pkg::CFG_SET_BITS) set_bits = val[2:0];
    else if (idx == salc_pkg::CFG_WAYS) ways = val[3:0];
    else if (idx == salc_pkg::CFG_BLOCK_BITS) block_bits = val;
  endfunction

  function logic [31:0] sat(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 1;
  endfunction

  function logic [1:0] lookup(logic [63:0] addr, logic [31:0] st);
    int s, e, base, victim, empty, sh;
    logic [63:0] setv, tag;
    s = (set_bits > 6) ? 6 : set_bits;
    e = (ways < 1) ? 1 : (ways > 8) ? 8 : ways;
    setv = (block_bits >= 64) ? 64'd0 : addr >> block_bits;
    setv = setv & ((64'd1 << s) - 1);
    sh = s + block_bits;
    tag = (sh >= 64) ? 64'd0 : addr >> sh;
    base = int'(setv) * 8;
    for (int i = 0; i < e; i++) begin
      if (valid_q[base+i] && tag_q[base+i] == tag) begin
        stamp_q[base+i] = st;
        hits = sat(hits);
        return salc_pkg::OUT_HIT;
      end
    end
    misses = sat(misses);
    empty = -1;
    for (int i = 0; i < e; i++) if (!valid_q[base+i]) empty = i;
    if (empty >= 0) victim = empty;
    else begin
      victim = 0;
      for (int i = 1; i < e; i++)
        if (stamp_q[base+i] < stamp_q[base+victim]) victim = i;
      evicts = sat(evicts);
    end
    valid_q[base+victim] = 1;
    tag_q[base+victim] = tag;
    stamp_q[base+victim] = st;
    return (empty >= 0) ? salc_pkg::OUT_FILL : salc_pkg::OUT_EVICT;
  endfunction

  function void push(logic [1:0] oc, logic lst);
    salc_pkg::out_t r;
    r.outcome = oc;
    r.last = lst;
    r.total_hits = hits;
    r.total_misses = misses;
    r.total_evictions = evicts;
    pending.push_back(r);
  endfunction

  function void note_request(salc_pkg::in_t req);
    logic [1:0] oc;
    if (req.kind == salc_pkg::KIND_LOAD || req.kind == salc_pkg::KIND_STORE) begin
      oc = lookup(req.address, acc_stamp);
      push(oc, 1'b1);
    end else if (req.kind == salc_pkg::KIND_MODIFY) begin
      oc = lookup(req.address, acc_stamp);
      push(oc, 1'b0);
      oc = lookup(req.address, acc_stamp);
      push(oc, 1'b1);
    end
    acc_stamp = sat(acc_stamp);
  endfunction

  function void check_result(salc_pkg::out_t got);
    salc_pkg::out_t want;
    results_seen++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display({"Mismatch: expected oc=%0d last=%0d h=%0d m=%0d e=%0d, ",
                  "got oc=%0d last=%0d h=%0d m=%0d e=%0d"},
                 want.outcome, want.last, want.total_hits, want.total_misses,
                 want.total_evictions, got.outcome, got.last, got.total_hits,
                 got.total_misses, got.total_evictions);
    end
  endfunction
endclass

module tb_top;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [5:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  salc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  salc_pkg::out_t out_data;

  cache_scoreboard board = new();
  int cycles = 0;
  int hold_off = 0;
  bit stall_mode = 0;
  int requests_sent = 0;
  logic [63:0] tag_pool[8];

  set_assoc_lru_cache_sim dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
    if (rst_n && in_valid && in_ready) board.note_request(in_data);
  end

  // The receiver stalls on its own pattern, with one long hold-off set by the test.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else if (stall_mode) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= 1;
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
  end

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send(logic [1:0] kind, logic [63:0] addr);
    @(negedge clk);
    in_valid <= 1;
    in_data <= {kind, addr};
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic send_burst(logic [1:0] kind, logic [63:0] addr, bit keep);
    // Holds valid across back-to-back requests when keep is set.
    in_valid <= 1;
    in_data <= {kind, addr};
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    @(negedge clk);
    if (!keep) in_valid <= 0;
  endtask

  function automatic logic [63:0] rand_addr(int mode);
    logic [63:0] a;
    a = {$urandom, $urandom};
    if (mode == 0) begin
      a = tag_pool[$urandom_range(0, 7)];
      a[5:0] = 6'($urandom);
    end
    return a;
  endfunction

  task automatic random_phase(int count);
    int n, burst;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 12);
      @(negedge clk);
      for (int k = 0; k < burst && n < count; k++) begin
        logic [1:0] kd;
        kd = ($urandom_range(0, 19) == 0) ? salc_pkg::KIND_NONE
                                          : 2'($urandom_range(0, 2));
        send_burst(kd, rand_addr($urandom_range(0, 4) == 0), k + 1 < burst && n + 1 < count);
        n++;
      end
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    drain();
  endtask

  initial begin
    int sb, wy, bb;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    for (int i = 0; i < 8; i++) tag_pool[i] = {$urandom, $urandom};

    // Directed part: extremes and every kind at reset settings, then out-of-range shapes.
    send(salc_pkg::KIND_LOAD, 64'd0);
    send(salc_pkg::KIND_STORE, 64'd0);
    send(salc_pkg::KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    send(salc_pkg::KIND_NONE, 64'h1234);
    send(salc_pkg::KIND_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send(salc_pkg::KIND_LOAD, 64'h8000_0000_0000_0000);
    drain();
    write_reg(salc_pkg::CFG_SET_BITS, 6'd7);
    write_reg(salc_pkg::CFG_WAYS, 6'd0);
    write_reg(salc_pkg::CFG_BLOCK_BITS, 6'd63);
    send(salc_pkg::KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    send(salc_pkg::KIND_LOAD, 64'h0);
    drain();
    write_reg(salc_pkg::CFG_SET_BITS, 6'd2);
    write_reg(salc_pkg::CFG_WAYS, 6'd15);
    write_reg(salc_pkg::CFG_BLOCK_BITS, 6'd32);
    for (int i = 0; i < 10; i++) send(salc_pkg::KIND_STORE, 64'(i) << 34);
    send(salc_pkg::KIND_LOAD, 64'd0);
    drain();
    write_reg(salc_pkg::CFG_WAYS, 6'd2);
    send(salc_pkg::KIND_LOAD, 64'd5 << 34);
    drain();

    // Long receiver hold-off while the sender keeps offering requests.
    write_reg(salc_pkg::CFG_SET_BITS, 6'd0);
    write_reg(salc_pkg::CFG_BLOCK_BITS, 6'd0);
    write_reg(salc_pkg::CFG_WAYS, 6'd8);
    hold_off = 300;
    random_phase(40);

    for (int ph = 0; ph < 12; ph++) begin
      sb = $urandom_range(0, 7);
      wy = $urandom_range(0, 15);
      bb = (ph % 4 == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
      if (ph == 3) begin sb = 6; wy = 8; bb = 0; end
      if (ph == 4) begin sb = 0; wy = 1; bb = 32; end
      write_reg(salc_pkg::CFG_SET_BITS, 6'(sb));
      write_reg(salc_pkg::CFG_WAYS, 6'(wy));
      write_reg(salc_pkg::CFG_BLOCK_BITS, 6'(bb));
      random_phase(100);
    end

    drain();
    $display("Sent %0d requests, checked %0d results over many cache shapes.",
             requests_sent, board.results_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> set_assoc_lru_cache_sim.f
rtl/salc_pkg.sv
rtl/salc_ctrl.sv
rtl/salc_dp.sv
rtl/set_assoc_lru_cache_sim.sv
rtl/salc_chk.sv
tb/tb_top.sv
